>>> src/dbsa_pkg.sv
// shared types and constants for the draw batch slot allocator
package dbsa_pkg;

	// field widths
	localparam int ID_W    = 32;
	localparam int VLIM_W  = 17;
	localparam int ILIM_W  = 18;
	localparam int TLIM_W  = 6;
	localparam int CFG_W   = 18;
	localparam int UNIT_W  = 6;

	// request actions
	localparam logic [1:0] ACT_TRI   = 2'd0;
	localparam logic [1:0] ACT_QUAD  = 2'd1;
	localparam logic [1:0] ACT_FLUSH = 2'd2;
	localparam logic [1:0] ACT_RSVD  = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_INDEX  = 2'd0;
	localparam logic [1:0] KIND_REJECT = 2'd1;
	localparam logic [1:0] KIND_BIND   = 2'd2;
	localparam logic [1:0] KIND_DRAW   = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_VERTEX_LIMIT = 2'd0;
	localparam logic [1:0] REG_INDEX_LIMIT  = 2'd1;
	localparam logic [1:0] REG_TEX_LIMIT    = 2'd2;

	// texture unit code for untextured primitives (-1)
	localparam logic [UNIT_W-1:0] UNIT_NONE = '1;

	// per-cell control from the sequencer
	typedef struct packed {
		logic compare;
		logic shift;
		logic write;
	} cell_ctrl_t;

	// vertex offset of each index entry of a quad
	function automatic logic [1:0] quad_offset(input logic [2:0] pos);
		logic [1:0] off;
		case (pos)
			3'd0: off = 2'd0;
			3'd1: off = 2'd1;
			3'd2: off = 2'd2;
			3'd3: off = 2'd2;
			3'd4: off = 2'd3;
			default: off = 2'd0;
		endcase
		return off;
	endfunction

endpackage

>>> src/dbsa_slot_cell.sv
// one texture slot cell: holds a bound id, matches it, shifts it toward slot 0
module dbsa_slot_cell
	import dbsa_pkg::*;
(
	input  logic            clk,
	input  cell_ctrl_t      ctrl,
	input  logic [ID_W-1:0] key,
	input  logic [ID_W-1:0] next_id,
	output logic [ID_W-1:0] slot_id,
	output logic            hit
);

	logic [ID_W-1:0] id_q;
	logic            hit_q;

	// slot contents: append writes, flush shifts down the row
	always_ff @(posedge clk) begin
		if (ctrl.write) begin
			id_q <= key;
		end else if (ctrl.shift) begin
			id_q <= next_id;
		end
	end

	// match against the incoming texture id
	always_ff @(posedge clk) begin
		if (ctrl.compare) begin
			hit_q <= (id_q == key);
		end
	end

	assign slot_id = id_q;
	assign hit     = hit_q;

endmodule

>>> src/draw_batch_slot_allocator.sv
// draw batch slot allocator top level: sequencer, counters and the row of slot cells
//
// A request is taken only while the sequencer is idle; a triangle or quad is decided
// in the next cycle. Results then leave through the single output register one per
// cycle unless the consumer stalls: three index results for a triangle, six for a
// quad, one for a rejection, and for a flush a bind per bound slot then a draw.
// The texture lookup is a parallel compare across the slot cells, registered at
// accept; a flush streams the bound ids out of slot 0 while the row shifts down
// one cell per cycle unless stalled. Action 3 is dropped without results.
module draw_batch_slot_allocator
	import dbsa_pkg::*;
#(
	parameter int VERTEX_CAPACITY = 65536,
	parameter int INDEX_CAPACITY  = 131072,
	parameter int TEX_SLOTS       = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_wr_en,
	input  logic [1:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	// request channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               action,
	input  logic                     has_texture,
	input  logic [31:0]              texture_id,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               kind,
	output logic signed [5:0]        tex_unit,
	output logic [31:0]              bound_id,
	output logic [15:0]              vertex_base,
	output logic [16:0]              index_position,
	output logic [15:0]              index_value,
	output logic [17:0]              draw_index_count,
	output logic [16:0]              draw_vertex_count,
	output logic                     last
);

	localparam int SCW = $clog2(TEX_SLOTS + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_REJECT = 3'd2;
	localparam logic [2:0] ST_INDEX  = 3'd3;
	localparam logic [2:0] ST_BIND   = 3'd4;
	localparam logic [2:0] ST_DRAW   = 3'd5;

	logic [2:0]        state_q;
	logic [VLIM_W-1:0] vlimit_q;
	logic [ILIM_W-1:0] ilimit_q;
	logic [TLIM_W-1:0] tlimit_q;
	logic [VLIM_W-1:0] vcnt_q;
	logic [ILIM_W-1:0] icnt_q;
	logic [SCW-1:0]    slot_cnt_q;
	logic [SCW-1:0]    ctr_q;
	logic [2:0]        pos_q;
	logic              quad_q;
	logic              tex_q;
	logic [ID_W-1:0]   key_q;
	logic [UNIT_W-1:0] unit_q;
	logic [VLIM_W-1:0] base_q;
	logic [ILIM_W-1:0] ibase_q;

	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [UNIT_W-1:0] unit_out_q;
	logic [ID_W-1:0]   bound_q;
	logic [15:0]       vbase_q;
	logic [16:0]       ipos_q;
	logic [15:0]       ival_q;
	logic [17:0]       dic_q;
	logic [16:0]       dvc_q;
	logic              last_q;

	logic              in_acc;
	logic              load;
	logic [ID_W-1:0]   cell_key;
	cell_ctrl_t        ctrl   [TEX_SLOTS];
	logic [ID_W-1:0]   ids    [TEX_SLOTS];
	logic [TEX_SLOTS-1:0] hits;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign load     = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlimit_q <= VLIM_W'(65536);
			ilimit_q <= ILIM_W'(131072);
			tlimit_q <= TLIM_W'(16);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_VERTEX_LIMIT: vlimit_q <= cfg_data[VLIM_W-1:0];
				REG_INDEX_LIMIT:  ilimit_q <= cfg_data[ILIM_W-1:0];
				REG_TEX_LIMIT:    tlimit_q <= cfg_data[TLIM_W-1:0];
				default: ;
			endcase
		end
	end

	// capacity checks and effective limits
	logic [VLIM_W:0]   vsum;
	logic [ILIM_W:0]   isum;
	logic [31:0]       vlim;
	logic [31:0]       ilim;
	logic [TLIM_W-1:0] tlim;
	logic              over;

	always_comb begin
		vsum = {1'b0, vcnt_q} + (quad_q ? (VLIM_W+1)'(4) : (VLIM_W+1)'(3));
		isum = {1'b0, icnt_q} + (quad_q ? (ILIM_W+1)'(6) : (ILIM_W+1)'(3));
		vlim = (32'(vlimit_q) > 32'(VERTEX_CAPACITY)) ? 32'(VERTEX_CAPACITY)
		                                              : 32'(vlimit_q);
		ilim = (32'(ilimit_q) > 32'(INDEX_CAPACITY)) ? 32'(INDEX_CAPACITY)
		                                             : 32'(ilimit_q);
		tlim = (tlimit_q > TLIM_W'(TEX_SLOTS)) ? TLIM_W'(TEX_SLOTS) : tlimit_q;
		over = (32'(vsum) > vlim) || (32'(isum) > ilim);
	end

	// first bound slot that matches, else the next free slot
	logic [SCW-1:0] slot_sel;
	logic           tex_fail;
	logic           reject;

	always_comb begin
		slot_sel = slot_cnt_q;
		for (int i = TEX_SLOTS - 1; i >= 0; i--) begin
			if (hits[i] && (SCW'(i) < slot_cnt_q)) begin
				slot_sel = SCW'(i);
			end
		end
		tex_fail = tex_q && (7'(slot_sel) >= 7'(tlim));
		reject   = over || tex_fail;
	end

	// row of slot cells
	assign cell_key = (state_q == ST_IDLE) ? texture_id : key_q;

	for (genvar g = 0; g < TEX_SLOTS; g++) begin : g_cell
		logic [ID_W-1:0] nxt;

		assign nxt = (g == TEX_SLOTS - 1) ? '0 : ids[(g + 1) % TEX_SLOTS];

		always_comb begin
			ctrl[g].compare = in_acc;
			ctrl[g].shift   = (state_q == ST_BIND) && load;
			ctrl[g].write   = (state_q == ST_DECIDE) && !reject && tex_q
			                  && (slot_sel == slot_cnt_q) && (slot_sel == SCW'(g));
		end

		dbsa_slot_cell u_cell (
			.clk     (clk),
			.ctrl    (ctrl[g]),
			.key     (cell_key),
			.next_id (nxt),
			.slot_id (ids[g]),
			.hit     (hits[g])
		);
	end

	// sequencer and batch counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vcnt_q     <= '0;
			icnt_q     <= '0;
			slot_cnt_q <= '0;
			ctr_q      <= '0;
			pos_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						ctr_q <= '0;
						pos_q <= '0;
						unique case (action)
							ACT_TRI, ACT_QUAD: state_q <= ST_DECIDE;
							ACT_FLUSH: state_q <= (slot_cnt_q != '0) ? ST_BIND : ST_DRAW;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DECIDE: begin
					if (reject) begin
						state_q <= ST_REJECT;
					end else begin
						if (tex_q && (slot_sel == slot_cnt_q)) begin
							slot_cnt_q <= slot_cnt_q + SCW'(1);
						end
						vcnt_q  <= vsum[VLIM_W-1:0];
						icnt_q  <= isum[ILIM_W-1:0];
						state_q <= ST_INDEX;
					end
				end
				ST_REJECT: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				ST_INDEX: begin
					if (load) begin
						pos_q <= pos_q + 3'd1;
						if (pos_q == (quad_q ? 3'd5 : 3'd2)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_BIND: begin
					if (load) begin
						ctr_q <= ctr_q + SCW'(1);
						if (ctr_q == slot_cnt_q - SCW'(1)) begin
							state_q <= ST_DRAW;
						end
					end
				end
				ST_DRAW: begin
					if (load) begin
						vcnt_q     <= '0;
						icnt_q     <= '0;
						slot_cnt_q <= '0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request and decision holding registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			quad_q <= (action == ACT_QUAD);
			tex_q  <= has_texture;
			key_q  <= texture_id;
		end
		if (state_q == ST_DECIDE) begin
			unit_q  <= tex_q ? UNIT_W'(slot_sel) : UNIT_NONE;
			base_q  <= vcnt_q;
			ibase_q <= icnt_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= (state_q == ST_REJECT) || (state_q == ST_INDEX)
			               || (state_q == ST_BIND) || (state_q == ST_DRAW);
		end
	end

	// output register payload
	logic [ILIM_W-1:0] ipos_sum;
	logic [1:0]        voff;

	assign ipos_sum = ibase_q + ILIM_W'(pos_q);
	assign voff     = quad_q ? quad_offset(pos_q) : pos_q[1:0];

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q     <= KIND_REJECT;
			unit_out_q <= '0;
			bound_q    <= '0;
			vbase_q    <= '0;
			ipos_q     <= '0;
			ival_q     <= '0;
			dic_q      <= '0;
			dvc_q      <= '0;
			last_q     <= 1'b1;
			case (state_q)
				ST_INDEX: begin
					kind_q     <= KIND_INDEX;
					unit_out_q <= unit_q;
					bound_q    <= tex_q ? key_q : '0;
					vbase_q    <= base_q[15:0];
					ipos_q     <= ipos_sum[16:0];
					ival_q     <= base_q[15:0] + 16'(voff);
					last_q     <= (pos_q == (quad_q ? 3'd5 : 3'd2));
				end
				ST_BIND: begin
					kind_q     <= KIND_BIND;
					unit_out_q <= UNIT_W'(ctr_q);
					bound_q    <= ids[0];
					last_q     <= 1'b0;
				end
				ST_DRAW: begin
					kind_q <= KIND_DRAW;
					dic_q  <= icnt_q;
					dvc_q  <= vcnt_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign kind              = kind_q;
	assign tex_unit          = unit_out_q;
	assign bound_id          = bound_q;
	assign vertex_base       = vbase_q;
	assign index_position    = ipos_q;
	assign index_value       = ival_q;
	assign draw_index_count  = dic_q;
	assign draw_vertex_count = dvc_q;
	assign last              = last_q;

	// bound slots never exceed the cell row
	a_slot_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(slot_cnt_q) <= 32'(TEX_SLOTS))
		else $error("slot count beyond cell row");

	// a real request always starts a run
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action != ACT_RSVD) |=> (state_q != ST_IDLE))
		else $error("accepted request produced no run");

	// bind streaming only with slots bound
	a_bind_has_slots: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BIND) |-> (slot_cnt_q != '0))
		else $error("bind phase with empty slot table");

	// reject and draw results always close their run
	a_closing_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (kind_q == KIND_REJECT || kind_q == KIND_DRAW)) |-> last_q)
		else $error("reject or draw result without last");

endmodule
